FILE: design/npcs_pkg.sv
// Package for the nearest palette colour search block.
// Holds the operation codes, field widths and the scan state type.
// No dependencies.
package npcs_pkg;

  localparam int unsigned IDX_W  = 8;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned COLOR_W = 3 * CHAN_W;
  localparam int unsigned SQ_W   = 2 * CHAN_W;
  localparam int unsigned DIST_W = 18;

  // Largest possible squared distance, three channels of 255 squared.
  localparam logic [DIST_W-1:0] DIST_MAX = 18'd195075;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage

FILE: design/npcs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used for the palette colour store. No dependencies.
module npcs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/nearest_palette_color_search.sv
// Nearest palette colour search: a write item is taken whenever the block is idle; a query
// result follows a scan that reads one palette entry per cycle from the colour RAM port,
// then waits in ST_DONE until the result register is free. No new item is taken from a
// query's acceptance until its result is loaded into the result register. Synchronous
// active-low reset clears all used marks and the control state; the colour RAM is not
// cleared.
module nearest_palette_color_search #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // operation
  input  logic                               in_tuser,
  // entry_index, entry_red, entry_green, entry_blue, entry_used, query_color
  input  logic [npcs_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // no_used_entry
  output logic                               out_tuser,
  // closest_index, best_distance
  output logic [npcs_pkg::OUT_DATA_W-1:0]    out_tdata
);

  import npcs_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

  // Input field unpacking.
  logic [IDX_W-1:0]   entry_index;
  logic [COLOR_W-1:0] entry_color;
  logic               entry_used;
  logic [COLOR_W-1:0] query_color;
  logic               in_acc;
  logic               wr_en;

  assign entry_index = in_tdata[7:0];
  assign entry_color = in_tdata[31:8];
  assign entry_used  = in_tdata[32];
  assign query_color = in_tdata[56:33];
  assign in_acc      = in_tvalid & in_tready;
  assign wr_en       = in_acc && (in_tuser == OP_WRITE)
                       && ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));

  state_t state_r, state_nxt;
  logic [AW-1:0]              addr_r, addr_nxt;
  logic [COLOR_W-1:0]         query_r;
  logic [PALETTE_ENTRIES-1:0] used_r;

  // Scan pipeline: read issue, RAM data, squares, compare.
  logic              s1_vld_r, s1_used_r;
  logic [AW-1:0]     s1_idx_r;
  logic [COLOR_W-1:0] ram_rdata;
  logic              s2_vld_r;
  logic [AW-1:0]     s2_idx_r;
  logic [SQ_W-1:0]   sq_r [3];
  logic [SQ_W-1:0]   sq_nxt [3];
  logic [DIST_W-1:0] dist_sum;

  logic              found_r;
  logic [DIST_W-1:0] best_r;
  logic [AW-1:0]     best_idx_r;
  logic              take_best;

  logic              out_vld_r;
  logic              out_none_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_free;

  npcs_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_color_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (entry_index[AW-1:0]),
    .wdata (entry_color),
    .re    (state_r == ST_SCAN),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_vld_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      ST_IDLE: begin
        addr_nxt = '0;
        if (in_acc && (in_tuser == OP_QUERY)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr_en) begin
      used_r[entry_index[AW-1:0]] <= entry_used;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == OP_QUERY)) begin
      query_r <= query_color;
    end
  end

  // Channel distances squared, one 8 by 8 multiplier per channel.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [CHAN_W-1:0] qc, pc, dc;
      qc = query_r[c*CHAN_W +: CHAN_W];
      pc = ram_rdata[c*CHAN_W +: CHAN_W];
      dc = (qc > pc) ? (qc - pc) : (pc - qc);
      sq_nxt[c] = SQ_W'(dc) * SQ_W'(dc);
    end
  end

  assign dist_sum  = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
  // Strict compare keeps the lowest index on equal distances.
  assign take_best = s2_vld_r && (!found_r || (dist_sum < best_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      s1_vld_r <= (state_r == ST_SCAN);
      s2_vld_r <= s1_vld_r && s1_used_r;
      if (state_r == ST_IDLE) begin
        found_r <= 1'b0;
      end else if (take_best) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= addr_r;
    s1_used_r <= used_r[addr_r];
    s2_idx_r  <= s1_idx_r;
    for (int c = 0; c < 3; c++) begin
      sq_r[c] <= sq_nxt[c];
    end
    if (take_best) begin
      best_r     <= dist_sum;
      best_idx_r <= s2_idx_r;
    end
  end

  // Result register: the next item may be taken while a result waits here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_none_r <= !found_r;
      out_idx_r  <= found_r ? IDX_W'(best_idx_r) : '0;
      out_dist_r <= found_r ? best_r : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_none_r;
  assign out_tdata  = {6'b0, out_dist_r, out_idx_r};

endmodule

FILE: design/npcs_checker.sv
// Port-level checker for the nearest palette colour search block, bound to
// the top level. Depends on npcs_pkg.
module npcs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic                            out_tuser,
  input logic [npcs_pkg::OUT_DATA_W-1:0] out_tdata
);

  import npcs_pkg::*;

  // A waiting result holds still until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An empty palette reports index zero and distance zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("empty-palette result carries data");

  // Distance never exceeds three full-scale channels and padding stays zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[25:8] <= DIST_MAX) && (out_tdata[31:26] == 6'b0))
    else $error("distance out of range");

  // A query occupies the scan, so the next cycle takes no item.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_QUERY) |=> !in_tready)
    else $error("item taken during a scan");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (.*);
